// ===== rtl/core/mfr_pkg.sv =====
package mfr_pkg;

    localparam logic [7:0] HEADER_BYTE         = 8'h3C;
    localparam int         MAX_PAYLOAD_DEFAULT = 60;
    localparam logic [15:0] CRC_INIT           = 16'hFFFF;
    localparam logic [15:0] CRC_POLY           = 16'hA001;

    localparam logic [1:0] CFG_OWN_ADDRESS    = 2'd0;
    localparam logic [1:0] CFG_STRICT_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_WANTED_COMMAND = 2'd2;

    localparam logic ACTION_BYTE    = 1'b0;
    localparam logic ACTION_TIMEOUT = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_ACCEPTED  = 3'd0,
        VERDICT_MALFORMED = 3'd1,
        VERDICT_BAD_CRC   = 3'd2,
        VERDICT_ADDRESS   = 3'd3,
        VERDICT_COMMAND   = 3'd4,
        VERDICT_TIMEOUT   = 3'd5
    } verdict_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        verdict_t    verdict;
        logic [7:0]  frame_sequence;
        logic [7:0]  frame_address;
        logic [7:0]  frame_command;
        logic [7:0]  frame_length;
        logic [15:0] frame_crc;
        logic [15:0] crc_computed;
    } result_t;

    typedef struct packed {
        logic [7:0] own_address;
        logic       strict_address_check;
        logic [7:0] wanted_command;
    } cfg_t;

endpackage

// ===== rtl/core/mfr_crc_byte.sv =====
module mfr_crc_byte
    import mfr_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    // bitwise reflected CRC-16, one byte per pass
    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

// ===== rtl/core/mfr_parser.sv =====
module mfr_parser
    import mfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       action,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_SEQ     = 8'b0000_0010,
        PH_ADDR    = 8'b0000_0100,
        PH_CMD     = 8'b0000_1000,
        PH_LEN     = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_CRC_LO  = 8'b0100_0000,
        PH_CRC_HI  = 8'b1000_0000
    } phase_t;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    phase_t      phase_reg,  phase_next;
    logic [7:0]  count_reg,  count_next;
    logic [7:0]  seq_reg,    seq_next;
    logic [7:0]  addr_reg,   addr_next;
    logic [7:0]  cmd_reg,    cmd_next;
    logic [7:0]  len_reg,    len_next;
    logic [15:0] crc_reg,    crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    logic [15:0] crc_in;
    logic [15:0] crc_new;
    logic [7:0]  count_inc;
    logic [15:0] crc_rx;

    assign crc_in    = (phase_reg == PH_HUNT) ? CRC_INIT : crc_reg;
    assign count_inc = count_reg + 8'd1;
    assign crc_rx    = {rx_byte, crc_lo_reg};

    mfr_crc_byte u_crc (
        .crc_in  (crc_in),
        .data    (rx_byte),
        .crc_out (crc_new)
    );

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        seq_next    = seq_reg;
        addr_next   = addr_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.frame_sequence = seq_reg;
        res.frame_address  = addr_reg;
        res.frame_command  = cmd_reg;
        res.frame_length   = len_reg;

        if (step)
        begin
            if (action == ACTION_TIMEOUT)
            begin
                res           = '0;
                res.kind      = KIND_VERDICT;
                res.verdict   = VERDICT_TIMEOUT;
                res_valid     = 1'b1;
                phase_next    = PH_HUNT;
                count_next    = '0;
                seq_next      = '0;
                addr_next     = '0;
                cmd_next      = '0;
                len_next      = '0;
                crc_next      = CRC_INIT;
                crc_lo_next   = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx_byte == HEADER_BYTE)
                        begin
                            crc_next   = crc_new;
                            phase_next = PH_SEQ;
                        end
                    end
                    PH_SEQ:
                    begin
                        seq_next   = rx_byte;
                        crc_next   = crc_new;
                        phase_next = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        addr_next  = rx_byte;
                        crc_next   = crc_new;
                        phase_next = PH_CMD;
                    end
                    PH_CMD:
                    begin
                        cmd_next   = rx_byte;
                        crc_next   = crc_new;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        len_next   = rx_byte;
                        crc_next   = crc_new;
                        count_next = '0;
                        if (rx_byte > MAX_LEN)
                        begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_VERDICT;
                            res.verdict      = VERDICT_MALFORMED;
                            res.frame_length = rx_byte;
                            phase_next       = PH_HUNT;
                            seq_next         = '0;
                            addr_next        = '0;
                            cmd_next         = '0;
                            len_next         = '0;
                            crc_next         = CRC_INIT;
                            crc_lo_next      = '0;
                        end
                        else if (rx_byte == 8'd0)
                        begin
                            phase_next = PH_CRC_LO;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        crc_next          = crc_new;
                        res_valid         = 1'b1;
                        res.kind          = KIND_PAYLOAD;
                        res.payload_byte  = rx_byte;
                        res.payload_index = count_reg;
                        count_next        = count_inc;
                        if (count_inc >= len_reg)
                        begin
                            phase_next = PH_CRC_LO;
                        end
                    end
                    PH_CRC_LO:
                    begin
                        crc_lo_next = rx_byte;
                        phase_next  = PH_CRC_HI;
                    end
                    PH_CRC_HI:
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_VERDICT;
                        res.frame_crc    = crc_rx;
                        res.crc_computed = crc_reg;
                        if (crc_rx != crc_reg)
                        begin
                            res.verdict = VERDICT_BAD_CRC;
                        end
                        else if (cfg.strict_address_check && addr_reg != cfg.own_address)
                        begin
                            res.verdict = VERDICT_ADDRESS;
                        end
                        else if (cmd_reg != cfg.wanted_command)
                        begin
                            res.verdict = VERDICT_COMMAND;
                        end
                        else
                        begin
                            res.verdict = VERDICT_ACCEPTED;
                        end
                        phase_next  = PH_HUNT;
                        count_next  = '0;
                        seq_next    = '0;
                        addr_next   = '0;
                        cmd_next    = '0;
                        len_next    = '0;
                        crc_next    = CRC_INIT;
                        crc_lo_next = '0;
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            count_reg  <= '0;
            seq_reg    <= '0;
            addr_reg   <= '0;
            cmd_reg    <= '0;
            len_reg    <= '0;
            crc_reg    <= CRC_INIT;
            crc_lo_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            seq_reg    <= seq_next;
            addr_reg   <= addr_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

endmodule

// ===== rtl/core/motor_frame_receiver.sv =====
// Byte-serial receiver for 0x3C-headed response frames checked with CRC-16/Modbus.
// One byte or timeout transfer can be taken every cycle; each passes an input register,
// the frame parser and a result register, and a result is offered once the result
// register holds it. While a result waits, the input register holds one more transfer
// and then the input stalls; a byte that gives no result also waits for the result
// register. Payload bytes come out as tentative results, one verdict ends each frame,
// and a timeout gives a verdict at any time. Configuration writes are taken every
// cycle and belong in gaps where no transfer is in flight.
module motor_frame_receiver
    import mfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_index,
    output logic [2:0]  verdict,
    output logic [7:0]  frame_sequence,
    output logic [7:0]  frame_address,
    output logic [7:0]  frame_command,
    output logic [7:0]  frame_length,
    output logic [15:0] frame_crc,
    output logic [15:0] crc_computed,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t       cfg_reg;
    logic       in_valid_reg,  in_valid_next;
    logic       in_action_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    logic       advance;
    logic       step;
    logic       res_valid;
    result_t    res;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign step      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = step && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address          <= 8'd1;
            cfg_reg.strict_address_check <= 1'b0;
            cfg_reg.wanted_command       <= 8'd0;
            in_valid_reg                 <= 1'b0;
            out_valid_reg                <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_OWN_ADDRESS:    cfg_reg.own_address          <= cfg_data;
                    CFG_STRICT_ADDRESS: cfg_reg.strict_address_check <= cfg_data[0];
                    CFG_WANTED_COMMAND: cfg_reg.wanted_command       <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_action_reg <= action;
            in_byte_reg   <= rx_byte;
        end
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    mfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .action    (in_action_reg),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign payload_byte   = out_reg.payload_byte;
    assign payload_index  = out_reg.payload_index;
    assign verdict        = out_reg.verdict;
    assign frame_sequence = out_reg.frame_sequence;
    assign frame_address  = out_reg.frame_address;
    assign frame_command  = out_reg.frame_command;
    assign frame_length   = out_reg.frame_length;
    assign frame_crc      = out_reg.frame_crc;
    assign crc_computed   = out_reg.crc_computed;

endmodule
